>>> rtl/cma_pkg.sv
// shared widths, register indexes and types of the calibrated moving average
`timescale 1ns / 1ps
`default_nettype none
package cma_pkg;

  // field widths
  localparam int RAW_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int CAL_W     = 16;
  localparam int DIFF_W    = RAW_W + 1;
  localparam int PROD_W    = DIFF_W + GAIN_W;
  localparam int FRAC_BITS = 8;
  localparam int SCALED_W  = PROD_W - FRAC_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 2'd3;

  // register reset values
  localparam logic signed [CFG_DATA_W-1:0] ZERO_OFFSET_RST = 16'sd0;
  localparam logic signed [CFG_DATA_W-1:0] GAIN_RST        = 16'sd256;
  localparam logic signed [CFG_DATA_W-1:0] LOW_LIMIT_RST   = 16'sh8000;
  localparam logic signed [CFG_DATA_W-1:0] HIGH_LIMIT_RST  = 16'sh7fff;

  typedef logic signed [CAL_W-1:0]  sample_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // handshake between the sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

>>> rtl/calibrated_moving_average_top.sv
// calibrated moving average: offset, gain, clamp and boxcar mean of sensor samples
//
// input channel: in_valid / in_ready with in_raw_sample; one request is one
//   raw signed 16-bit sample
// result channel: out_valid / out_ready with out_calibrated_sample and
//   out_filtered_average; each request gives exactly one result
// config port: cfg_we with cfg_index and cfg_data, written while the block is idle
// the bit-serial multiplier (one gain bit a cycle) followed by the restoring
//   divider (one quotient bit a cycle) runs one request at a time; a new
//   request is taken only after the last result has been loaded
// the result sits in an output register; in_ready comes back as soon as the
//   sequencer is idle, so a stalled receiver only blocks once the next result
//   is finished and still has nowhere to go
// reset: config registers return to offset 0, gain 1.0, full 16-bit limits;
//   running sum, write pointer and fill count clear; ring entries not yet
//   written are masked by the fill count, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module calibrated_moving_average_top #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [cma_pkg::RAW_W-1:0]        in_raw_sample,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [cma_pkg::CAL_W-1:0]       out_calibrated_sample,
  output logic signed [cma_pkg::CAL_W-1:0]       out_filtered_average,
  input  wire                                    cfg_we,
  input  wire        [cma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire        [cma_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = cma_pkg::CAL_W + $clog2(WINDOW_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                 state_r;
  logic [2:0]                 state_nxt;

  // configuration registers
  cma_pkg::sample_t           zero_offset_r;
  cma_pkg::sample_t           gain_r;
  cma_pkg::sample_t           low_limit_r;
  cma_pkg::sample_t           high_limit_r;

  // window state
  cma_pkg::sample_t           ring_mem [WINDOW_DEPTH];
  cma_pkg::sample_t           ring_rd_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [PTR_W-1:0]           wptr_r;
  logic [PTR_W-1:0]           wptr_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic                       full;
  cma_pkg::sample_t           old_sample;

  // datapath
  cma_pkg::sample_t           cal_r;
  cma_pkg::sample_t           cal_nxt;
  cma_pkg::diff_t             diff;
  cma_pkg::prod_t             product;
  logic signed [cma_pkg::SCALED_W-1:0] scaled;
  logic signed [cma_pkg::SCALED_W-1:0] low_ext;
  logic signed [cma_pkg::SCALED_W-1:0] high_ext;
  logic signed [SUM_W-1:0]    quotient;

  // output register
  logic                       out_valid_r;
  cma_pkg::sample_t           out_cal_r;
  cma_pkg::sample_t           out_avg_r;

  logic                       in_fire;
  logic                       load_out;

  cma_pkg::unit_req_t         mul_req;
  cma_pkg::unit_stat_t        mul_stat;
  cma_pkg::unit_req_t         div_req;
  cma_pkg::unit_stat_t        div_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= cma_pkg::ZERO_OFFSET_RST;
      gain_r        <= cma_pkg::GAIN_RST;
      low_limit_r   <= cma_pkg::LOW_LIMIT_RST;
      high_limit_r  <= cma_pkg::HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cma_pkg::REG_ZERO_OFFSET: zero_offset_r <= $signed(cfg_data);
        cma_pkg::REG_GAIN:        gain_r        <= $signed(cfg_data);
        cma_pkg::REG_LOW_LIMIT:   low_limit_r   <= $signed(cfg_data);
        cma_pkg::REG_HIGH_LIMIT:  high_limit_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- scaling
  // offset removal is exact in 17 bits; the multiplier walks the gain bits
  assign diff          = cma_pkg::DIFF_W'(in_raw_sample) - cma_pkg::DIFF_W'(zero_offset_r);
  assign mul_req.start = in_fire;

  cma_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .mcand   (diff),
    .mplier  (gain_r),
    .stat    (mul_stat),
    .product (product)
  );

  // arithmetic shift is floor division by 256; low limit is tested first
  always_comb begin
    scaled   = product[cma_pkg::PROD_W-1:cma_pkg::FRAC_BITS];
    low_ext  = cma_pkg::SCALED_W'(low_limit_r);
    high_ext = cma_pkg::SCALED_W'(high_limit_r);
    priority if (scaled < low_ext) begin
      cal_nxt = low_limit_r;
    end else if (scaled > high_ext) begin
      cal_nxt = high_limit_r;
    end else begin
      cal_nxt = scaled[cma_pkg::CAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- window
  // slots past the fill count were never written and count as zero
  always_comb begin
    full       = (cnt_r == CNT_W'(WINDOW_DEPTH));
    old_sample = full ? ring_rd_r : '0;
    sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(cal_r);
    wptr_nxt   = (wptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : (wptr_r + PTR_W'(1));
    cnt_nxt    = full ? cnt_r : (cnt_r + CNT_W'(1));
  end

  // the read at the write pointer settles during the multiply, before the write
  always_ff @(posedge clk) begin
    ring_rd_r <= ring_mem[wptr_r];
    if (state_r == S_SUM) begin
      ring_mem[wptr_r] <= cal_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      wptr_r <= '0;
      cnt_r  <= '0;
    end else if (state_r == S_SUM) begin
      sum_r  <= sum_nxt;
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLAMP) begin
      cal_r <= cal_nxt;
    end
  end

  // ---------------------------------------------------------------- mean
  assign div_req.start = (state_r == S_SUM);

  cma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_MUL;
      S_MUL:   if (mul_stat.done) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_OUT;
      S_OUT:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cal_r <= cal_r;
      out_avg_r <= quotient[cma_pkg::CAL_W-1:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_calibrated_sample = out_cal_r;
  assign out_filtered_average  = out_avg_r;

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count past window depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= PTR_W'(WINDOW_DEPTH - 1))
    else $error("write pointer past window depth");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL))
    else $error("multiplier finished outside multiply phase");

  a_div_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |=> div_stat.busy && (state_r == S_DIV))
    else $error("divider did not start after sum update");

  a_cal_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (low_limit_r <= high_limit_r)) |=>
      (out_cal_r >= low_limit_r) && (out_cal_r <= high_limit_r))
    else $error("calibrated sample outside limits");

endmodule
`default_nettype wire

>>> rtl/cma_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cma_mul (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire cma_pkg::unit_req_t req,
  input  wire cma_pkg::diff_t  mcand,
  input  wire signed [cma_pkg::GAIN_W-1:0] mplier,
  output cma_pkg::unit_stat_t  stat,
  output cma_pkg::prod_t       product
);

  localparam int CNT_W = $clog2(cma_pkg::GAIN_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  cma_pkg::prod_t              acc_r;
  cma_pkg::prod_t              acc_nxt;
  cma_pkg::prod_t              mc_r;
  cma_pkg::prod_t              addend;
  logic [cma_pkg::GAIN_W-1:0]  mp_r;
  logic                        last;

  // the top multiplier bit carries negative weight
  always_comb begin
    last    = (cnt_r == CNT_W'(cma_pkg::GAIN_W - 1));
    addend  = mp_r[0] ? mc_r : '0;
    acc_nxt = last ? (acc_r - addend) : (acc_r + addend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      mc_r  <= cma_pkg::PROD_W'(mcand);
      mp_r  <= mplier;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mc_r  <= mc_r <<< 1;
      mp_r  <= mp_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule
`default_nettype wire

>>> rtl/cma_div.sv
// restoring divider, signed dividend by unsigned divisor, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cma_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 5
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire cma_pkg::unit_req_t  req,
  input  wire signed [NUM_W-1:0]   dividend,
  input  wire        [DEN_W-1:0]   divisor,
  output cma_pkg::unit_stat_t      stat,
  output logic signed [NUM_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic              neg_r;
  logic              zero_r;
  logic [NUM_W-1:0]  q_r;
  logic [NUM_W-1:0]  q_nxt;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic [NUM_W-1:0]  mag;
  logic              fits;
  logic              last;

  always_comb begin
    mag      = dividend[NUM_W-1] ? (NUM_W'(0) - dividend) : dividend;
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    fits     = (rem_sh >= {1'b0, den_r});
    rem_diff = rem_sh - {1'b0, den_r};
    rem_nxt  = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    q_nxt    = {q_r[NUM_W-2:0], fits};
    last     = (cnt_r == STEP_W'(NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r    <= mag;
      rem_r  <= '0;
      den_r  <= divisor;
      neg_r  <= dividend[NUM_W-1];
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign; a zero divisor gives zero
  always_comb begin
    if (zero_r) begin
      quotient = '0;
    end else if (neg_r) begin
      quotient = $signed(NUM_W'(0) - q_r);
    end else begin
      quotient = $signed(q_r);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

>>> verif/tb_calibrated_moving_average_top.sv
// self-checking testbench for the calibrated moving average top level
`timescale 1ns / 1ps
module tb_calibrated_moving_average_top;

  localparam int WINDOW_DEPTH  = 16;
  localparam int SUM_W         = cma_pkg::CAL_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int LATENCY       = 41;     // accept to out_valid at a 16-deep window
  localparam int QUIET_LIMIT   = 4000;   // cycles without traffic before giving up
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off, fills the block
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 150;
  localparam int MAX_IDLE      = 6;
  localparam int DIRECTED_ROWS = 34;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  // one row of the directed plan: either a register write or a sample request
  typedef struct {
    step_kind_t                     kind;
    logic [cma_pkg::CFG_IDX_W-1:0]  index;
    logic [cma_pkg::CFG_DATA_W-1:0] data;
    cma_pkg::sample_t               raw;
    bit                             typed;   // expected values below are hand-written
    cma_pkg::sample_t               cal;
    cma_pkg::sample_t               avg;
  } plan_step_t;

  typedef struct {
    cma_pkg::sample_t cal;
    cma_pkg::sample_t avg;
  } window_result_t;

  // dut ports
  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  cma_pkg::sample_t               in_raw_sample;
  logic                           out_valid;
  logic                           out_ready;
  cma_pkg::sample_t               out_calibrated_sample;
  cma_pkg::sample_t               out_filtered_average;
  logic                           cfg_we;
  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cma_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the calibration registers
  cma_pkg::sample_t cal_offset;
  cma_pkg::sample_t cal_gain;
  cma_pkg::sample_t cal_low;
  cma_pkg::sample_t cal_high;

  // predictor copy of the averaging window
  cma_pkg::sample_t        ring [WINDOW_DEPTH];
  logic signed [SUM_W-1:0] ring_sum;
  int                      ring_slot;
  int                      ring_fill;

  window_result_t pending_results[$];
  plan_step_t     directed_plan [DIRECTED_ROWS];

  int mismatches;
  int samples_sent;
  int directed_count;
  int results_seen;
  int writes_done;
  int settings_done;
  int hold_request;
  int holds_done;
  bit calm;   // both sides run without idle cycles while set

  calibrated_moving_average_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_raw_sample         (in_raw_sample),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_calibrated_sample (out_calibrated_sample),
    .out_filtered_average  (out_filtered_average),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offset, gain, floor shift, clamp (low test first), then window mean
  function automatic window_result_t calibrate_sample(cma_pkg::sample_t raw);
    cma_pkg::diff_t                      diff;
    cma_pkg::prod_t                      prod;
    logic signed [cma_pkg::SCALED_W-1:0] scaled;
    window_result_t                      res;
    diff = raw - cal_offset;
    prod = diff * cal_gain;
    // arithmetic shift of a signed product is a floor divide by 256
    scaled = prod >>> cma_pkg::FRAC_BITS;
    if (scaled < cal_low) begin
      res.cal = cal_low;
    end else if (scaled > cal_high) begin
      res.cal = cal_high;
    end else begin
      res.cal = cma_pkg::sample_t'(scaled);
    end
    // replace the oldest ring entry and keep the sum exact
    ring_sum = ring_sum - ring[ring_slot] + res.cal;
    ring[ring_slot] = res.cal;
    ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
    if (ring_fill < WINDOW_DEPTH) begin
      ring_fill++;
    end
    // signed divide truncates toward zero
    res.avg = cma_pkg::sample_t'(ring_sum / ring_fill);
    return res;
  endfunction

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // one register write; cfg_we stays high so writes can go back to back
  task automatic write_reg(logic [cma_pkg::CFG_IDX_W-1:0] index,
                           logic [cma_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      cma_pkg::REG_ZERO_OFFSET: cal_offset = data;
      cma_pkg::REG_GAIN:        cal_gain   = data;
      cma_pkg::REG_LOW_LIMIT:   cal_low    = data;
      cma_pkg::REG_HIGH_LIMIT:  cal_high   = data;
      default: ;
    endcase
    writes_done++;
  endtask

  // offer one sample request and record its expected result at acceptance
  task automatic send_sample(cma_pkg::sample_t raw, bit typed, window_result_t typed_res);
    int             gap;
    window_result_t res;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    res = calibrate_sample(raw);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(res);
    end
    samples_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // result side: random stalls per result, plus the one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_draw();
      if (hold_request > 0) begin
        stall += hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: cal %0d avg %0d",
                                out_calibrated_sample, out_filtered_average));
      end else begin
        want = pending_results.pop_front();
        if (out_calibrated_sample !== want.cal) begin
          flag_mismatch($sformatf("result %0d calibrated_sample %0d, want %0d",
                                  results_seen, out_calibrated_sample, want.cal));
        end
        if (out_filtered_average !== want.avg) begin
          flag_mismatch($sformatf("result %0d filtered_average %0d, want %0d",
                                  results_seen, out_filtered_average, want.avg));
        end
      end
    end
  end

  // watchdog: too long without any handshake or register write ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout after %0d quiet cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("calibrated_moving_average_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int               phase;
    int               n;
    bit               last_was_write;
    window_result_t   typed_res;
    cma_pkg::sample_t raw;
    cma_pkg::sample_t set_offset;
    cma_pkg::sample_t set_gain;
    cma_pkg::sample_t set_low;
    cma_pkg::sample_t set_high;

    // every input known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_raw_sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_request  = 0;

    // predictor at its reset state
    cal_offset = cma_pkg::ZERO_OFFSET_RST;
    cal_gain   = cma_pkg::GAIN_RST;
    cal_low    = cma_pkg::LOW_LIMIT_RST;
    cal_high   = cma_pkg::HIGH_LIMIT_RST;
    foreach (ring[i]) ring[i] = '0;
    ring_sum  = '0;
    ring_slot = 0;
    ring_fill = 0;

    // directed plan: hand-written results only right after reset
    directed_plan = '{
      // reset settings: unity gain, full range; first mean is the sample itself
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh7fff, 1'b1, 16'sh7fff, 16'sh7fff},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh8000, 1'b1, 16'sh8000, 16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd0,    1'b1, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd1,    1'b1, 16'sd1,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd1,   1'b1, -16'sd1,   16'sd0},
      // most negative gain with largest offset
      '{STEP_WRITE,  cma_pkg::REG_GAIN,        16'h8000, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_ZERO_OFFSET, 16'h7fff, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh8000, 1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh7fff, 1'b0, 16'sd0,    16'sd0},
      // largest gain with most negative offset
      '{STEP_WRITE,  cma_pkg::REG_GAIN,        16'h7fff, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_ZERO_OFFSET, 16'h8000, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh7fff, 1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh8000, 1'b0, 16'sd0,    16'sd0},
      // tiny gain: shift floors negative products
      '{STEP_WRITE,  cma_pkg::REG_GAIN,        16'h0001, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd1,   1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd255,  1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd256, 1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd257, 1'b0, 16'sd0,    16'sd0},
      // narrow limits: below, above and inside
      '{STEP_WRITE,  cma_pkg::REG_GAIN,        16'h0100, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_LOW_LIMIT,   16'hff9c, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_HIGH_LIMIT,  16'h0064, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd5000, 1'b0, 16'sd0,   16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd5000, 1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd50,   1'b0, 16'sd0,    16'sd0},
      // crossed limits: low test wins, everything else lands on high
      '{STEP_WRITE,  cma_pkg::REG_LOW_LIMIT,   16'h0064, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_HIGH_LIMIT,  16'hff9c, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd50,   1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd100,  1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, -16'sd200, 1'b0, 16'sd0,    16'sd0},
      // limits crossed at the extremes
      '{STEP_WRITE,  cma_pkg::REG_LOW_LIMIT,   16'h7fff, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_WRITE,  cma_pkg::REG_HIGH_LIMIT,  16'h8000, 16'sd0,    1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sh7fff, 1'b0, 16'sd0,    16'sd0},
      '{STEP_SAMPLE, cma_pkg::REG_ZERO_OFFSET, 16'h0000, 16'sd0,    1'b0, 16'sd0,    16'sd0}
    };

    // synchronous reset, then release
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: registers change only once the block has drained
    last_was_write = 1'b0;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_WRITE) begin
        if (!last_was_write) begin
          wait_for_results();
          settings_done++;
        end
        write_reg(directed_plan[i].index, directed_plan[i].data);
        last_was_write = 1'b1;
      end else begin
        if (last_was_write) begin
          cfg_we <= 1'b0;
        end
        typed_res.cal = directed_plan[i].cal;
        typed_res.avg = directed_plan[i].avg;
        send_sample(directed_plan[i].raw, directed_plan[i].typed, typed_res);
        directed_count++;
        last_was_write = 1'b0;
      end
    end

    // random part: a new register setting per phase, written while idle
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      if (phase == 0) begin
        // back to reset settings, no idle cycles at all
        set_offset = cma_pkg::ZERO_OFFSET_RST;
        set_gain   = cma_pkg::GAIN_RST;
        set_low    = cma_pkg::LOW_LIMIT_RST;
        set_high   = cma_pkg::HIGH_LIMIT_RST;
      end else if (phase == RANDOM_PHASES - 1) begin
        // extreme gain and offset over the full range
        set_offset = 16'sh7fff;
        set_gain   = 16'sh8000;
        set_low    = cma_pkg::LOW_LIMIT_RST;
        set_high   = cma_pkg::HIGH_LIMIT_RST;
      end else begin
        set_offset = $urandom_range(0, 1)
                       ? cma_pkg::sample_t'($urandom)
                       : cma_pkg::sample_t'(int'($urandom_range(0, 512)) - 256);
        case ($urandom_range(0, 3))
          0:       set_gain = cma_pkg::GAIN_RST;
          1:       set_gain = cma_pkg::sample_t'($urandom);
          2:       set_gain = cma_pkg::sample_t'(int'($urandom_range(0, 2048)) - 1024);
          default: set_gain = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
        case ($urandom_range(0, 3))
          0: begin
            set_low  = cma_pkg::LOW_LIMIT_RST;
            set_high = cma_pkg::HIGH_LIMIT_RST;
          end
          1: begin
            // crossed on purpose
            set_low  = cma_pkg::sample_t'($urandom_range(0, 20000));
            set_high = cma_pkg::sample_t'(-int'($urandom_range(0, 20000)));
          end
          2: begin
            set_low  = cma_pkg::sample_t'($urandom);
            set_high = cma_pkg::sample_t'($urandom);
          end
          default: begin
            set_low  = cma_pkg::sample_t'(-int'($urandom_range(0, 20000)));
            set_high = cma_pkg::sample_t'($urandom_range(0, 20000));
          end
        endcase
      end
      write_reg(cma_pkg::REG_ZERO_OFFSET, set_offset);
      write_reg(cma_pkg::REG_GAIN, set_gain);
      write_reg(cma_pkg::REG_LOW_LIMIT, set_low);
      write_reg(cma_pkg::REG_HIGH_LIMIT, set_high);
      cfg_we <= 1'b0;
      settings_done++;
      calm = (phase == 0);

      for (n = 0; n < PHASE_SAMPLES; n++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 2 && n == 10) begin
          hold_request = HOLD_CYCLES;
        end
        // sender pause until the pipeline is empty, mid-stream
        if (phase == 3 && n == PHASE_SAMPLES / 2) begin
          wait_for_results();
        end
        // a stretch of full-rate traffic in the middle of an idling phase
        if (phase == 4) begin
          calm = (n >= 50 && n < 100);
        end
        // mostly full-range samples, some close to the offset
        if ($urandom_range(0, 9) < 6) begin
          raw = cma_pkg::sample_t'($urandom);
        end else begin
          raw = cma_pkg::sample_t'(int'(cal_offset) + int'($urandom_range(0, 1024)) - 512);
        end
        send_sample(raw, 1'b0, typed_res);
      end
    end
    calm = 1'b0;

    // drain, then give any stray result time to show up
    wait_for_results();
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d sample requests (%0d directed) over %0d register settings",
             samples_sent, directed_count, settings_done);
    $display("checked %0d results, %0d register writes, %0d long receiver hold-off(s)",
             results_seen, writes_done, holds_done);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("calibrated_moving_average_top regression: pass");
    end else begin
      $display("calibrated_moving_average_top regression: fail");
    end
    $finish;
  end

endmodule

>>> calibrated_moving_average_top.f
rtl/cma_pkg.sv
rtl/cma_mul.sv
rtl/cma_div.sv
rtl/calibrated_moving_average_top.sv
verif/tb_calibrated_moving_average_top.sv
